// ===== hw/rtl/hb2_pkg.sv =====
`timescale 1ns / 1ps
// hb2_pkg: shared types, s-box tables and round helper functions for the hummingbird-2 core
package hb2_pkg;

    typedef logic [15:0] t_word;
    typedef logic [3:0]  t_sbox [4][16];

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_LO  = 2'd0;
    localparam logic [1:0] CFG_KEY_HI  = 2'd1;
    localparam logic [1:0] CFG_IV      = 2'd2;
    localparam logic [1:0] CFG_DECRYPT = 2'd3;

    // forward s-boxes, nibble i goes through box i
    localparam t_sbox SBOX_FWD = '{
        '{4'h7, 4'hC, 4'hE, 4'h9, 4'h2, 4'h1, 4'h5, 4'hF,
          4'hB, 4'h6, 4'hD, 4'h0, 4'h4, 4'h8, 4'hA, 4'h3},
        '{4'h4, 4'hA, 4'h1, 4'h6, 4'h8, 4'hF, 4'h7, 4'hC,
          4'h3, 4'h0, 4'hE, 4'hD, 4'h5, 4'h9, 4'hB, 4'h2},
        '{4'h2, 4'hF, 4'hC, 4'h1, 4'h5, 4'h6, 4'hA, 4'hD,
          4'hE, 4'h8, 4'h3, 4'h4, 4'h0, 4'hB, 4'h9, 4'h7},
        '{4'hF, 4'h4, 4'h5, 4'h8, 4'h9, 4'h7, 4'h2, 4'h1,
          4'hA, 4'h3, 4'h0, 4'hE, 4'h6, 4'hC, 4'hD, 4'hB}
    };

    // inverse s-boxes
    localparam t_sbox SBOX_INV = '{
        '{4'hB, 4'h5, 4'h4, 4'hF, 4'hC, 4'h6, 4'h9, 4'h0,
          4'hD, 4'h3, 4'hE, 4'h8, 4'h1, 4'hA, 4'h2, 4'h7},
        '{4'h9, 4'h2, 4'hF, 4'h8, 4'h0, 4'hC, 4'h3, 4'h6,
          4'h4, 4'hD, 4'h1, 4'hE, 4'h7, 4'hB, 4'hA, 4'h5},
        '{4'hC, 4'h3, 4'h0, 4'hA, 4'hB, 4'h4, 4'h5, 4'hF,
          4'h9, 4'hE, 4'h6, 4'hD, 4'h2, 4'h7, 4'h8, 4'h1},
        '{4'hA, 4'h7, 4'h6, 4'h9, 4'h1, 4'h2, 4'hC, 4'h5,
          4'h3, 4'h4, 4'h8, 4'hF, 4'hD, 4'hE, 4'hB, 4'h0}
    };

    // rotate left by a constant amount
    function automatic t_word rotl(t_word x, logic [3:0] s);
        logic [31:0] d;
        d = {x, x} << s;
        return d[31:16];
    endfunction

    // s-box layer, forward or inverse
    function automatic t_word apply_sbox(t_word x, logic inv);
        t_word y;
        for (int i = 0; i < 4; i++) begin
            y[4*i +: 4] = inv ? SBOX_INV[i][x[4*i +: 4]] : SBOX_FWD[i][x[4*i +: 4]];
        end
        return y;
    endfunction

    // linear layer
    function automatic t_word lin(t_word x);
        return x ^ rotl(x, 4'd6) ^ rotl(x, 4'd10);
    endfunction

    // inverse linear layer
    function automatic t_word lin_inv(t_word y);
        return y ^ rotl(y, 4'd2) ^ rotl(y, 4'd4) ^ rotl(y, 4'd12) ^ rotl(y, 4'd14);
    endfunction

endpackage

// ===== hw/rtl/hb2_fround.sv =====
`timescale 1ns / 1ps
// hb2_fround: shared keyed f round, forward (key, s-box, linear) or inverse
module hb2_fround (
    input  logic [15:0] i_x,
    input  logic [15:0] i_key,
    input  logic        i_inv,
    output logic [15:0] o_y
);

    hb2_pkg::t_word w_fwd;
    hb2_pkg::t_word w_inv;

    // forward round: mix key, substitute, diffuse
    always_comb begin
        w_fwd = hb2_pkg::lin(hb2_pkg::apply_sbox(i_x ^ i_key, 1'b0));
    end

    // inverse round: undo diffusion, substitute back, mix key
    always_comb begin
        w_inv = hb2_pkg::apply_sbox(hb2_pkg::lin_inv(i_x), 1'b1) ^ i_key;
    end

    assign o_y = i_inv ? w_inv : w_fwd;

endmodule

// ===== hw/rtl/hummingbird2_word_cipher.sv =====
`timescale 1ns / 1ps
// Hummingbird-2 word cipher: 16-bit words through one shared f round unit
// each word runs 16 f rounds (four layers of four f rounds) and then one state update;
// a word marked first of a message first runs the four initialization rounds
// a new word is accepted only when idle, after the last result has gone to the output register
// reset (synchronous, active low) clears the state words, the configuration registers and all control
module hummingbird2_word_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_word_in,
    input  logic        i_first_of_message,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_word_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    // configuration
    logic [63:0] r_key_lo;
    logic [63:0] r_key_hi;
    logic [63:0] r_iv;
    logic        r_dec;

    // cipher state and working registers
    hb2_pkg::t_word r_st [8];
    hb2_pkg::t_word r_w;
    hb2_pkg::t_word r_x;
    hb2_pkg::t_word r_t1;
    hb2_pkg::t_word r_t2;
    hb2_pkg::t_word r_t3;
    hb2_pkg::t_word r_res;
    hb2_pkg::t_word r_out;
    logic           r_out_valid;

    // sequencer
    logic [1:0] r_state;
    logic       r_init;
    logic [1:0] r_rnd;
    logic [1:0] r_layer;
    logic [1:0] r_step;

    logic           w_in_acc;
    logic           w_out_free;
    logic           w_inv;
    logic [1:0]     w_kidx;
    logic           w_sel_hi;
    logic           w_mask;
    hb2_pkg::t_word w_kbase;
    hb2_pkg::t_word w_key;
    hb2_pkg::t_word w_layer_in;
    hb2_pkg::t_word w_x;
    hb2_pkg::t_word w_y;
    hb2_pkg::t_word w_post;
    hb2_pkg::t_word w_i0;
    hb2_pkg::t_word w_i1;
    hb2_pkg::t_word w_i2;
    hb2_pkg::t_word w_i3;
    hb2_pkg::t_word w_s3;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_word_out  = r_out;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // direction: initialization always runs forward
    assign w_inv  = r_dec && !r_init;
    assign w_kidx = w_inv ? ~r_step : r_step;

    // subkey set of the current layer
    always_comb begin
        if (r_init) begin
            w_sel_hi = r_layer[0];
            w_mask   = 1'b0;
        end else if (r_dec) begin
            w_sel_hi = (r_layer == 2'd0) || (r_layer == 2'd2);
            w_mask   = (r_layer == 2'd1) || (r_layer == 2'd2);
        end else begin
            w_sel_hi = (r_layer == 2'd1) || (r_layer == 2'd3);
            w_mask   = (r_layer == 2'd1) || (r_layer == 2'd2);
        end
    end

    // subkey word, optionally mixed with the upper state words
    always_comb begin
        case (w_kidx)
            2'd0:    w_kbase = w_sel_hi ? r_key_hi[63:48] : r_key_lo[63:48];
            2'd1:    w_kbase = w_sel_hi ? r_key_hi[47:32] : r_key_lo[47:32];
            2'd2:    w_kbase = w_sel_hi ? r_key_hi[31:16] : r_key_lo[31:16];
            default: w_kbase = w_sel_hi ? r_key_hi[15:0]  : r_key_lo[15:0];
        endcase
        w_key = w_kbase ^ (w_mask ? r_st[{1'b1, w_kidx}] : 16'h0000);
    end

    // value entering a layer
    always_comb begin
        if (r_layer == 2'd0) begin
            if (r_init) begin
                w_layer_in = r_st[0] - {14'd0, r_rnd};
            end else if (r_dec) begin
                w_layer_in = r_w - r_st[0];
            end else begin
                w_layer_in = r_st[0] + r_w;
            end
        end else if (r_dec && !r_init) begin
            w_layer_in = r_x;
        end else begin
            w_layer_in = r_st[{1'b0, r_layer}] + r_x;
        end
        w_x = (r_step == 2'd0) ? w_layer_in : r_x;
    end

    hb2_fround u_fround (
        .i_x   (w_x),
        .i_key (w_key),
        .i_inv (w_inv),
        .o_y   (w_y)
    );

    // value leaving a layer
    always_comb begin
        if (r_init) begin
            w_post = w_y;
        end else if (r_dec) begin
            w_post = w_y - r_st[{1'b0, ~r_layer}];
        end else if (r_layer == 2'd3) begin
            w_post = w_y + r_st[0];
        end else begin
            w_post = w_y;
        end
    end

    // next state words of an initialization round
    always_comb begin
        w_i0 = hb2_pkg::rotl(r_st[0] + w_y, 4'd3);
        w_i1 = hb2_pkg::rotl(r_st[1] + r_t1, 4'd15);
        w_i2 = hb2_pkg::rotl(r_st[2] + r_t2, 4'd8);
        w_i3 = hb2_pkg::rotl(r_st[3] + r_t3, 4'd1);
    end

    // word state update term
    assign w_s3 = r_st[3] + r_st[0] + r_t3 + r_t1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= 64'd0;
            r_key_hi <= 64'd0;
            r_iv     <= 64'd0;
            r_dec    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hb2_pkg::CFG_KEY_LO:  r_key_lo <= i_cfg_data;
                hb2_pkg::CFG_KEY_HI:  r_key_hi <= i_cfg_data;
                hb2_pkg::CFG_IV:      r_iv     <= i_cfg_data;
                hb2_pkg::CFG_DECRYPT: r_dec    <= i_cfg_data[0];
                default:              r_dec    <= r_dec;
            endcase
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_init      <= 1'b0;
            r_rnd       <= 2'd0;
            r_layer     <= 2'd0;
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_st[i] <= 16'h0000;
            end
        end else begin
            // the update cycle reloads the output register itself
            if (r_out_valid && i_out_ready && (r_state != ST_UPD)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_w     <= i_word_in;
                        r_layer <= 2'd0;
                        r_step  <= 2'd0;
                        r_rnd   <= 2'd0;
                        r_init  <= i_first_of_message;
                        r_state <= ST_RUN;
                        if (i_first_of_message) begin
                            r_st[0] <= r_iv[63:48];
                            r_st[1] <= r_iv[47:32];
                            r_st[2] <= r_iv[31:16];
                            r_st[3] <= r_iv[15:0];
                            r_st[4] <= r_iv[63:48];
                            r_st[5] <= r_iv[47:32];
                            r_st[6] <= r_iv[31:16];
                            r_st[7] <= r_iv[15:0];
                        end
                    end
                end
                ST_RUN: begin
                    r_step <= r_step + 2'd1;
                    if (r_step != 2'd3) begin
                        r_x <= w_y;
                    end else begin
                        r_x     <= w_post;
                        r_layer <= r_layer + 2'd1;
                        if (r_init) begin
                            // initialization round: keep t1..t3, finish on the last layer
                            case (r_layer)
                                2'd0: r_t1 <= w_y;
                                2'd1: r_t2 <= w_y;
                                2'd2: r_t3 <= w_y;
                                default: begin
                                    r_st[0] <= w_i0;
                                    r_st[1] <= w_i1;
                                    r_st[2] <= w_i2;
                                    r_st[3] <= w_i3;
                                    r_st[4] <= r_st[4] ^ w_i0;
                                    r_st[5] <= r_st[5] ^ w_i1;
                                    r_st[6] <= r_st[6] ^ w_i2;
                                    r_st[7] <= r_st[7] ^ w_i3;
                                    r_rnd   <= r_rnd + 2'd1;
                                    if (r_rnd == 2'd3) begin
                                        r_init <= 1'b0;
                                    end
                                end
                            endcase
                        end else begin
                            // word layers: encrypt gives t1,t2,t3; decrypt gives t3,t2,t1
                            case (r_layer)
                                2'd0: begin
                                    if (r_dec) r_t3 <= w_post;
                                    else       r_t1 <= w_post;
                                end
                                2'd1: r_t2 <= w_post;
                                2'd2: begin
                                    if (r_dec) r_t1 <= w_post;
                                    else       r_t3 <= w_post;
                                end
                                default: begin
                                    r_res   <= w_post;
                                    r_state <= ST_UPD;
                                end
                            endcase
                        end
                    end
                end
                ST_UPD: begin
                    // update state and hand the result to the output register
                    if (w_out_free) begin
                        r_st[7]     <= r_st[7] ^ w_s3;
                        r_st[6]     <= r_st[6] ^ (r_st[2] + r_t2);
                        r_st[5]     <= r_st[5] ^ (r_st[1] + r_t1);
                        r_st[4]     <= r_st[4] ^ (r_st[0] + r_t3);
                        r_st[3]     <= w_s3;
                        r_st[2]     <= r_st[2] + r_t2;
                        r_st[1]     <= r_st[1] + r_t1;
                        r_st[0]     <= r_st[0] + r_t3;
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // a first item always starts with initialization
    a_first_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_first_of_message) |=> r_init)
        else $error("initialization not started on first item");

    // initialization only happens while the round unit runs
    a_init_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> (r_state == ST_RUN))
        else $error("initialization flag outside run state");

    // a result appears only out of the update cycle
    a_out_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_UPD))
        else $error("result raised outside update");

    // a full, stalled output register holds the update back
    a_upd_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && r_out_valid && !i_out_ready) |=> (r_state == ST_UPD))
        else $error("state updated over a pending result");

    // counters are parked while idle
    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_step == 2'd0 && r_layer == 2'd0 && !r_init))
        else $error("sequencer counters not parked in idle");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench for the hummingbird-2 word cipher: word-level predictor, random handshakes, scoreboard
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_WORDS   = 400;

    // one nibble per entry, entry 0 in the top nibble
    localparam logic [63:0] BOX_FWD [4] = '{
        64'h7CE9_215F_B6D0_48A3, 64'h4A16_8F7C_30ED_59B2,
        64'h2FC1_56AD_E834_0B97, 64'hF458_9721_A30E_6CDB
    };
    localparam logic [63:0] BOX_INV [4] = '{
        64'hB54F_C690_D3E8_1A27, 64'h92F8_0C36_4D1E_7BA5,
        64'hC30A_B45F_9E6D_2781, 64'hA769_12C5_348F_DEB0
    };

    typedef struct packed {
        logic [15:0] word;
        logic        first;
    } t_word_item;

    // dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = hb2_pkg::CFG_KEY_LO;
    logic [63:0] i_cfg_data = 64'h0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_word_in = 16'h0;
    logic        i_first_of_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_word_out;

    // predictor copy of the cipher state and registers
    logic [15:0] cipher_regs [8] = '{default: 16'h0};
    logic [63:0] key_lo = 64'h0;
    logic [63:0] key_hi = 64'h0;
    logic [63:0] iv_words = 64'h0;
    logic        decrypting = 1'b0;

    t_word_item  pending_words [$];
    logic [15:0] due_words [$];

    int words_queued = 0;
    int words_sent = 0;
    int words_checked = 0;
    int words_decrypted = 0;
    int words_opening = 0;
    int reg_writes = 0;
    int fail_count = 0;
    int burst_left = 8;
    int gap_left = 0;
    int idle_cycles = 0;
    int ready_pos = 0;
    logic [31:0] ready_pat = '1;

    hummingbird2_word_cipher i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_word_in          (i_word_in),
        .i_first_of_message (i_first_of_message),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_word_out         (o_word_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [15:0] rol16(logic [15:0] x, int s);
        return (x << s) | (x >> (16 - s));
    endfunction

    // four 4-bit substitutions, nibble i through box i
    function automatic logic [15:0] nibble_subst(logic [15:0] x, logic inv);
        logic [15:0] y;
        for (int i = 0; i < 4; i++) begin
            if (inv) begin
                y[4*i +: 4] = BOX_INV[i][63 - 4*x[4*i +: 4] -: 4];
            end else begin
                y[4*i +: 4] = BOX_FWD[i][63 - 4*x[4*i +: 4] -: 4];
            end
        end
        return y;
    endfunction

    function automatic logic [15:0] f_fwd(logic [15:0] x);
        logic [15:0] s;
        s = nibble_subst(x, 1'b0);
        return s ^ rol16(s, 6) ^ rol16(s, 10);
    endfunction

    function automatic logic [15:0] f_inv(logic [15:0] y);
        logic [15:0] s;
        s = y ^ rol16(y, 2) ^ rol16(y, 4) ^ rol16(y, 12) ^ rol16(y, 14);
        return nibble_subst(s, 1'b1);
    endfunction

    // keyed 16-bit mixing: four f rounds, subkey word 0 in bits 63..48
    function automatic logic [15:0] wd_fwd(logic [15:0] x, logic [63:0] k);
        for (int i = 0; i < 4; i++) begin
            x = f_fwd(x ^ k[63 - 16*i -: 16]);
        end
        return x;
    endfunction

    function automatic logic [15:0] wd_inv(logic [15:0] y, logic [63:0] k);
        for (int i = 3; i >= 0; i--) begin
            y = f_inv(y) ^ k[63 - 16*i -: 16];
        end
        return y;
    endfunction

    // expected output word for one accepted input, advances the predicted state
    function automatic logic [15:0] predict_cipher_word(logic [15:0] w, logic first);
        logic [15:0] t1, t2, t3, t4, res;
        logic [63:0] mb, mc;
        if (first) begin
            words_opening++;
            for (int i = 0; i < 4; i++) begin
                cipher_regs[i]     = iv_words[63 - 16*i -: 16];
                cipher_regs[i + 4] = iv_words[63 - 16*i -: 16];
            end
            // initialization rounds, round index taken off word 0
            for (int rnd = 0; rnd < 4; rnd++) begin
                t1 = wd_fwd(cipher_regs[0] - 16'(rnd), key_lo);
                t2 = wd_fwd(cipher_regs[1] + t1, key_hi);
                t3 = wd_fwd(cipher_regs[2] + t2, key_lo);
                t4 = wd_fwd(cipher_regs[3] + t3, key_hi);
                cipher_regs[0] = rol16(cipher_regs[0] + t4, 3);
                cipher_regs[1] = rol16(cipher_regs[1] + t1, 15);
                cipher_regs[2] = rol16(cipher_regs[2] + t2, 8);
                cipher_regs[3] = rol16(cipher_regs[3] + t3, 1);
                for (int i = 0; i < 4; i++) begin
                    cipher_regs[i + 4] ^= cipher_regs[i];
                end
            end
        end
        mb = key_hi ^ {cipher_regs[4], cipher_regs[5], cipher_regs[6], cipher_regs[7]};
        mc = key_lo ^ {cipher_regs[4], cipher_regs[5], cipher_regs[6], cipher_regs[7]};
        if (decrypting) begin
            words_decrypted++;
            t3  = wd_inv(w - cipher_regs[0], key_hi) - cipher_regs[3];
            t2  = wd_inv(t3, mc) - cipher_regs[2];
            t1  = wd_inv(t2, mb) - cipher_regs[1];
            res = wd_inv(t1, key_lo) - cipher_regs[0];
        end else begin
            t1  = wd_fwd(cipher_regs[0] + w, key_lo);
            t2  = wd_fwd(cipher_regs[1] + t1, mb);
            t3  = wd_fwd(cipher_regs[2] + t2, mc);
            res = wd_fwd(cipher_regs[3] + t3, key_hi) + cipher_regs[0];
        end
        // state update from the old words
        cipher_regs[7] ^= 16'(cipher_regs[3] + cipher_regs[0] + t3 + t1);
        cipher_regs[6] ^= 16'(cipher_regs[2] + t2);
        cipher_regs[5] ^= 16'(cipher_regs[1] + t1);
        cipher_regs[4] ^= 16'(cipher_regs[0] + t3);
        cipher_regs[3] = cipher_regs[3] + cipher_regs[0] + t3 + t1;
        cipher_regs[2] = cipher_regs[2] + t2;
        cipher_regs[1] = cipher_regs[1] + t1;
        cipher_regs[0] = cipher_regs[0] + t3;
        return res;
    endfunction

    // word sender: bursts of random length, random gaps between them
    always @(posedge i_clk) begin : send_words
        t_word_item nxt;
        logic       slot_free;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            slot_free = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                due_words.push_back(predict_cipher_word(i_word_in, i_first_of_message));
                words_sent++;
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    nxt = pending_words.pop_front();
                    i_in_valid         <= 1'b1;
                    i_word_in          <= nxt.word;
                    i_first_of_message <= nxt.first;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(1, 5);
                            2: gap_left = $urandom_range(6, 25);
                            default: gap_left = $urandom_range(26, 60);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: checks each word, stalls following a random 32-bit ready pattern
    always @(posedge i_clk) begin : take_results
        logic [15:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_words.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected output word %04h", o_word_out);
                end
                fail_count++;
            end else begin
                want = due_words.pop_front();
                words_checked++;
                if (o_word_out !== want) begin
                    if (fail_count < 10) begin
                        $display("word %0d mismatch: expected %04h, got %04h",
                                 words_checked, want, o_word_out);
                    end
                    fail_count++;
                end
            end
        end
        if (ready_pos == 31) begin
            ready_pos = 0;
            case ($urandom_range(0, 4))
                0, 1: ready_pat = '1;
                2: ready_pat = $urandom | (32'd1 << $urandom_range(0, 31));
                3: ready_pat = ($urandom & $urandom) | (32'd1 << $urandom_range(0, 31));
                default: ready_pat = ($urandom & $urandom & $urandom)
                                     | (32'd1 << $urandom_range(0, 31));
            endcase
        end else begin
            ready_pos++;
        end
        i_out_ready <= ready_pat[ready_pos];
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_word(input logic [15:0] w, input logic first);
        pending_words.push_back('{word: w, first: first});
        words_queued++;
    endtask

    // wait until every queued word has gone in and come back
    task automatic drain_words();
        while (!(words_sent == words_queued && due_words.size() == 0)) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            hb2_pkg::CFG_KEY_LO:  key_lo = val;
            hb2_pkg::CFG_KEY_HI:  key_hi = val;
            hb2_pkg::CFG_IV:      iv_words = val;
            hb2_pkg::CFG_DECRYPT: decrypting = val[0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [63:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // stimulus
    initial begin
        logic [1:0] reg_ids [4];
        int         n_msgs;
        int         msg_len;
        logic       carry_on;
        reg_ids = '{hb2_pkg::CFG_KEY_LO, hb2_pkg::CFG_KEY_HI, hb2_pkg::CFG_IV,
                    hb2_pkg::CFG_DECRYPT};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // straight after reset: zero key, words with no message start yet, then a message start
        queue_word(16'h0000, 1'b0);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h0000, 1'b1);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h8000, 1'b0);
        queue_word(16'h0001, 1'b0);
        drain_words();

        // all-ones registers, decrypting
        write_reg(hb2_pkg::CFG_KEY_LO, '1);
        write_reg(hb2_pkg::CFG_KEY_HI, '1);
        write_reg(hb2_pkg::CFG_IV, '1);
        write_reg(hb2_pkg::CFG_DECRYPT, 64'd1);
        queue_word(16'hFFFF, 1'b1);
        queue_word(16'h0000, 1'b0);
        queue_word(16'h5A5A, 1'b0);
        queue_word(16'hFFFF, 1'b1);
        drain_words();

        // a new message, then key and mode changed mid-message, then a new iv that waits for a start
        write_reg(hb2_pkg::CFG_KEY_LO, {$urandom, $urandom});
        write_reg(hb2_pkg::CFG_KEY_HI, 64'h0);
        write_reg(hb2_pkg::CFG_IV, {$urandom, $urandom});
        write_reg(hb2_pkg::CFG_DECRYPT, 64'd0);
        queue_word(16'h1234, 1'b1);
        queue_word(16'hA5A5, 1'b0);
        queue_word(16'h0000, 1'b0);
        drain_words();
        write_reg(hb2_pkg::CFG_KEY_HI, {$urandom, $urandom});
        write_reg(hb2_pkg::CFG_DECRYPT, 64'd1);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h00FF, 1'b0);
        drain_words();
        write_reg(hb2_pkg::CFG_IV, {$urandom, $urandom});
        queue_word(16'hFF00, 1'b0);
        queue_word(16'h7777, 1'b1);
        drain_words();

        // random phases: a few register writes, then a handful of messages
        while (words_queued < RANDOM_WORDS + 19) begin
            foreach (reg_ids[r]) begin
                if ($urandom_range(0, 1) == 1) begin
                    if (reg_ids[r] == hb2_pkg::CFG_DECRYPT) begin
                        write_reg(reg_ids[r], {63'h0, 1'($urandom_range(0, 1))});
                    end else begin
                        write_reg(reg_ids[r], pick_reg_value());
                    end
                end
            end
            n_msgs = $urandom_range(1, 4);
            carry_on = ($urandom_range(0, 5) == 0);
            for (int m = 0; m < n_msgs; m++) begin
                msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24)
                                                      : $urandom_range(1, 10);
                for (int k = 0; k < msg_len; k++) begin
                    queue_word(pick_word(), (k == 0) && !(m == 0 && carry_on));
                end
            end
            drain_words();
        end

        drain_words();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        fail_count += due_words.size();
        $display("checked %0d words: %0d decrypted, %0d opening a message, %0d register writes",
                 words_checked, words_decrypted, words_opening, reg_writes);
        $display("%0d bad or unexpected words", fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
